### hdl/complex_iir_filter_top_defines.svh
// ----------------------------------------------------------------------------
// complex_iir_filter_top_defines.svh
// Assertion macros shared by the checker.
// ----------------------------------------------------------------------------
`ifndef COMPLEX_IIR_FILTER_TOP_DEFINES_SVH
`define COMPLEX_IIR_FILTER_TOP_DEFINES_SVH

// same-cycle implication
`define CIIR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("complex iir filter check failed");

// next-cycle implication
`define CIIR_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("complex iir filter check failed");

`endif

### hdl/ciir_pkg.sv
// ----------------------------------------------------------------------------
// ciir_pkg
// Types, codes and widths shared by the complex IIR filter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ciir_pkg;

	localparam int SAMPLE_BITS = 16;  // Q1.15
	localparam int COEF_BITS = 16;    // Q2.14
	localparam int COUNT_BITS = 5;
	localparam int TAP_INDEX_BITS = 4;
	localparam int CFG_INDEX_BITS = 1;
	localparam int CFG_DATA_BITS = COUNT_BITS;

	localparam int MAX_FORWARD_TAPS_DEF = 16;
	localparam int MAX_FEEDBACK_TAPS_DEF = 16;

	localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = ~SAMPLE_MAX;

	typedef enum logic [1:0] {
		ACT_FILTER  = 2'd0,
		ACT_LOAD_FF = 2'd1,
		ACT_LOAD_FB = 2'd2
	} action_t;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		CFG_FF_COUNT = 1'b0,
		CFG_FB_COUNT = 1'b1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FF,
		ST_FB,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] re;
		logic signed [SAMPLE_BITS-1:0] im;
	} sample_cplx_t;

	typedef struct packed {
		logic signed [COEF_BITS-1:0] re;
		logic signed [COEF_BITS-1:0] im;
	} coef_cplx_t;

	typedef struct packed {
		action_t                       action;
		logic signed [SAMPLE_BITS-1:0] sample_re;
		logic signed [SAMPLE_BITS-1:0] sample_im;
		logic [TAP_INDEX_BITS-1:0]     tap_index;
		logic signed [COEF_BITS-1:0]   tap_re;
		logic signed [COEF_BITS-1:0]   tap_im;
	} sample_word_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] out_re;
		logic signed [SAMPLE_BITS-1:0] out_im;
		logic                          clipped;
	} result_word_t;

endpackage

### hdl/ciir_ram.sv
// ----------------------------------------------------------------------------
// ciir_ram
// One write port, one registered read port, per-entry valid bits so that
// an entry never written reads as zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ciir_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 32,
	parameter int AW = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [DEPTH-1:0] valid_q;
	logic [WIDTH-1:0] rd_data_q;
	logic             wr_ok;
	logic             rd_ok;

	assign wr_ok = wr_en && ((AW+1)'(wr_addr) < (AW+1)'(DEPTH));
	assign rd_ok = (AW+1)'(rd_addr) < (AW+1)'(DEPTH);

	always_ff @(posedge clk) begin
		if (wr_ok) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_ok && valid_q[rd_addr]) begin
			rd_data_q <= mem[rd_addr];
		end else begin
			rd_data_q <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_ok) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	assign rd_data = rd_data_q;

endmodule

### hdl/ciir_cmac.sv
// ----------------------------------------------------------------------------
// ciir_cmac
// Shared complex multiply-accumulate: four products registered, then a
// wide complex accumulate. One term per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ciir_cmac #(
	parameter int ACC_BITS = 40
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       clr,
	input  logic                       en,
	input  ciir_pkg::coef_cplx_t       tap,
	input  ciir_pkg::sample_cplx_t     smp,
	output logic                       busy,
	output logic signed [ACC_BITS-1:0] acc_re,
	output logic signed [ACC_BITS-1:0] acc_im
);

	localparam int PW = ciir_pkg::SAMPLE_BITS + ciir_pkg::COEF_BITS;

	logic signed [PW-1:0]       p_rr_s1, p_ii_s1, p_ri_s1, p_ir_s1;
	logic                       valid_s1;
	logic signed [ACC_BITS-1:0] term_re, term_im;
	logic signed [ACC_BITS-1:0] acc_re_q, acc_im_q;

	always_ff @(posedge clk) begin
		p_rr_s1 <= tap.re * smp.re;
		p_ii_s1 <= tap.im * smp.im;
		p_ri_s1 <= tap.re * smp.im;
		p_ir_s1 <= tap.im * smp.re;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= en;
		end
	end

	assign term_re = ACC_BITS'(p_rr_s1) - ACC_BITS'(p_ii_s1);
	assign term_im = ACC_BITS'(p_ri_s1) + ACC_BITS'(p_ir_s1);

	always_ff @(posedge clk) begin
		if (clr) begin
			acc_re_q <= '0;
			acc_im_q <= '0;
		end else if (valid_s1) begin
			acc_re_q <= acc_re_q + term_re;
			acc_im_q <= acc_im_q + term_im;
		end
	end

	assign busy = valid_s1;
	assign acc_re = acc_re_q;
	assign acc_im = acc_im_q;

endmodule

### hdl/complex_iir_filter_top.sv
// ----------------------------------------------------------------------------
// complex_iir_filter_top
// Direct form I IIR filter on complex Q1.15 samples with complex Q2.14 taps.
// ----------------------------------------------------------------------------
// A filter word runs N feedforward terms and then max(M-1, 0) feedback
// terms, N and M being the feedforward and feedback counts clamped to the
// tap store depths; a filter word with a feedforward count of zero runs
// no terms and gives a zero result. The work is done by the single
// complex multiply-accumulate unit, which takes one tap term per cycle
// from the single read port of each tap and history memory. No word is
// taken while a sample is in work. The result sits in an output register,
// so a new word may be taken while a result waits; the next result then
// waits until that one is taken. Config writes are always ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module complex_iir_filter_top #(
	parameter int MAX_FORWARD_TAPS = ciir_pkg::MAX_FORWARD_TAPS_DEF,
	parameter int MAX_FEEDBACK_TAPS = ciir_pkg::MAX_FEEDBACK_TAPS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 sample_valid,
	output logic                                 sample_stall,
	input  ciir_pkg::sample_word_t               sample_word,
	output logic                                 result_valid,
	input  logic                                 result_stall,
	output ciir_pkg::result_word_t               result_word,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [ciir_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [ciir_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

	localparam int SB = ciir_pkg::SAMPLE_BITS;
	localparam int CB = ciir_pkg::COEF_BITS;
	localparam int FF_AW = (MAX_FORWARD_TAPS > 1) ? $clog2(MAX_FORWARD_TAPS) : 1;
	localparam int FB_AW = (MAX_FEEDBACK_TAPS > 1) ? $clog2(MAX_FEEDBACK_TAPS) : 1;
	localparam int MAX_TAPS = (MAX_FORWARD_TAPS > MAX_FEEDBACK_TAPS) ?
		MAX_FORWARD_TAPS : MAX_FEEDBACK_TAPS;
	localparam int CNT_W = ($clog2(MAX_TAPS + 1) > ciir_pkg::COUNT_BITS) ?
		$clog2(MAX_TAPS + 1) : ciir_pkg::COUNT_BITS;
	localparam int AW_MAX = (FF_AW > FB_AW) ? FF_AW : FB_AW;
	localparam int TAP_IW = ((AW_MAX > ciir_pkg::TAP_INDEX_BITS) ?
		AW_MAX : ciir_pkg::TAP_INDEX_BITS) + 1;
	localparam int ACC_BITS = SB + CB + 2 + $clog2(MAX_FORWARD_TAPS + MAX_FEEDBACK_TAPS);
	localparam int SHIFT = CB - 2;
	localparam logic signed [ACC_BITS-1:0] RND = ACC_BITS'(64'sd1 <<< (SHIFT - 1));
	localparam logic signed [ACC_BITS-1:0] SAT_HI = ACC_BITS'((64'sd1 <<< (SB - 1)) - 64'sd1);
	localparam logic signed [ACC_BITS-1:0] SAT_LO = ~SAT_HI;

	ciir_pkg::state_t state_q, state_d;

	logic [ciir_pkg::COUNT_BITS-1:0] ffc_q, fbc_q;
	logic [CNT_W-1:0]                n_eff, m_eff, idx_q;
	logic [FF_AW-1:0]                ipos_q;
	logic [FB_AW-1:0]                opos_q;
	ciir_pkg::sample_cplx_t          x_q;
	logic                            zero_q;
	logic                            rd_s1, fb_s1, selx_s1;
	logic                            res_valid_q;
	ciir_pkg::result_word_t          res_q;

	logic             accept, is_filter, issue, fb_phase, last_ff, last_fb, fb_more;
	logic             finish_go, mac_clr, mac_busy;
	logic [TAP_IW-1:0] tap_idx_ext;
	logic             ff_tap_we, fb_tap_we;
	logic [FF_AW:0]   ih_sum;
	logic [FB_AW:0]   oh_sum;
	logic [FF_AW-1:0] ih_addr;
	logic [FB_AW-1:0] oh_addr;
	logic [2*CB-1:0]  fft_rd, fbt_rd;
	logic [2*SB-1:0]  ih_rd, oh_rd;
	ciir_pkg::coef_cplx_t   mac_tap;
	ciir_pkg::sample_cplx_t mac_smp, y_cplx;
	logic signed [ACC_BITS-1:0] acc_re, acc_im;
	logic [SB:0]      rs_re, rs_im;
	ciir_pkg::result_word_t y_word;

	// round half up by SHIFT bits, saturate; result is {clip, value}
	function automatic logic [SB:0] round_sat(input logic signed [ACC_BITS-1:0] a);
		logic signed [ACC_BITS-1:0] sh;
		sh = (a + RND) >>> SHIFT;
		if (sh > SAT_HI) begin
			return {1'b1, SB'(SAT_HI)};
		end else if (sh < SAT_LO) begin
			return {1'b1, SB'(SAT_LO)};
		end
		return {1'b0, SB'(sh)};
	endfunction

	assign n_eff = (CNT_W'(ffc_q) > CNT_W'(MAX_FORWARD_TAPS)) ?
		CNT_W'(MAX_FORWARD_TAPS) : CNT_W'(ffc_q);
	assign m_eff = (CNT_W'(fbc_q) > CNT_W'(MAX_FEEDBACK_TAPS)) ?
		CNT_W'(MAX_FEEDBACK_TAPS) : CNT_W'(fbc_q);
	assign last_ff = (idx_q == n_eff - CNT_W'(1));
	assign last_fb = (idx_q == m_eff - CNT_W'(1));
	assign fb_more = (m_eff > CNT_W'(1));

	assign sample_stall = (state_q != ciir_pkg::ST_IDLE);
	assign accept = sample_valid && !sample_stall;
	assign is_filter = (sample_word.action == ciir_pkg::ACT_FILTER);
	assign finish_go = (state_q == ciir_pkg::ST_FINISH) && (!res_valid_q || !result_stall);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ciir_pkg::ST_IDLE: begin
				if (accept && is_filter) begin
					state_d = (n_eff == '0) ? ciir_pkg::ST_FINISH : ciir_pkg::ST_FF;
				end
			end
			ciir_pkg::ST_FF: begin
				if (last_ff) begin
					state_d = fb_more ? ciir_pkg::ST_FB : ciir_pkg::ST_DRAIN;
				end
			end
			ciir_pkg::ST_FB: begin
				if (last_fb) begin
					state_d = ciir_pkg::ST_DRAIN;
				end
			end
			ciir_pkg::ST_DRAIN: begin
				if (!rd_s1 && !mac_busy) begin
					state_d = ciir_pkg::ST_FINISH;
				end
			end
			ciir_pkg::ST_FINISH: begin
				if (finish_go) begin
					state_d = ciir_pkg::ST_IDLE;
				end
			end
			default: state_d = ciir_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		issue = 1'b0;
		fb_phase = 1'b0;
		mac_clr = 1'b0;
		unique case (state_q)
			ciir_pkg::ST_IDLE: mac_clr = accept && is_filter;
			ciir_pkg::ST_FF: issue = 1'b1;
			ciir_pkg::ST_FB: begin
				issue = 1'b1;
				fb_phase = 1'b1;
			end
			ciir_pkg::ST_DRAIN, ciir_pkg::ST_FINISH: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ciir_pkg::ST_IDLE;
			idx_q <= '0;
			ipos_q <= '0;
			opos_q <= '0;
			zero_q <= 1'b0;
			rd_s1 <= 1'b0;
			fb_s1 <= 1'b0;
			selx_s1 <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			rd_s1 <= issue;
			fb_s1 <= fb_phase;
			selx_s1 <= issue && !fb_phase && (idx_q == '0);
			if (accept && is_filter) begin
				idx_q <= '0;
				zero_q <= (n_eff == '0);
			end else if (state_q == ciir_pkg::ST_FF && last_ff) begin
				idx_q <= CNT_W'(1);
			end else if (issue) begin
				idx_q <= idx_q + CNT_W'(1);
			end
			if (finish_go && !zero_q) begin
				ipos_q <= (ipos_q == '0) ? FF_AW'(MAX_FORWARD_TAPS - 1) : ipos_q - FF_AW'(1);
				opos_q <= (opos_q == '0) ? FB_AW'(MAX_FEEDBACK_TAPS - 1) : opos_q - FB_AW'(1);
			end
			if (finish_go) begin
				res_valid_q <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && is_filter) begin
			x_q <= {sample_word.sample_re, sample_word.sample_im};
		end
		if (finish_go) begin
			res_q <= y_word;
		end
	end

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ffc_q <= ciir_pkg::COUNT_BITS'(1);
			fbc_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (ciir_pkg::cfg_reg_t'(cfg_index))
				ciir_pkg::CFG_FF_COUNT: ffc_q <= cfg_data;
				ciir_pkg::CFG_FB_COUNT: fbc_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// tap loads
	assign tap_idx_ext = TAP_IW'(sample_word.tap_index);
	assign ff_tap_we = accept && (sample_word.action == ciir_pkg::ACT_LOAD_FF) &&
		(tap_idx_ext < TAP_IW'(MAX_FORWARD_TAPS));
	assign fb_tap_we = accept && (sample_word.action == ciir_pkg::ACT_LOAD_FB) &&
		(tap_idx_ext < TAP_IW'(MAX_FEEDBACK_TAPS));

	// circular history addresses, next write at pos, newest stored entry at pos + 1
	assign ih_sum = {1'b0, ipos_q} + (FF_AW+1)'(idx_q);
	assign oh_sum = {1'b0, opos_q} + (FB_AW+1)'(idx_q);
	assign ih_addr = (ih_sum >= (FF_AW+1)'(MAX_FORWARD_TAPS)) ?
		FF_AW'(ih_sum - (FF_AW+1)'(MAX_FORWARD_TAPS)) : FF_AW'(ih_sum);
	assign oh_addr = (oh_sum >= (FB_AW+1)'(MAX_FEEDBACK_TAPS)) ?
		FB_AW'(oh_sum - (FB_AW+1)'(MAX_FEEDBACK_TAPS)) : FB_AW'(oh_sum);

	ciir_ram #(.DEPTH(MAX_FORWARD_TAPS), .WIDTH(2*CB), .AW(FF_AW)) u_ff_taps (
		.clk(clk), .arst_n(arst_n),
		.wr_en(ff_tap_we), .wr_addr(FF_AW'(tap_idx_ext)),
		.wr_data({sample_word.tap_re, sample_word.tap_im}),
		.rd_addr(FF_AW'(idx_q)), .rd_data(fft_rd)
	);

	ciir_ram #(.DEPTH(MAX_FEEDBACK_TAPS), .WIDTH(2*CB), .AW(FB_AW)) u_fb_taps (
		.clk(clk), .arst_n(arst_n),
		.wr_en(fb_tap_we), .wr_addr(FB_AW'(tap_idx_ext)),
		.wr_data({sample_word.tap_re, sample_word.tap_im}),
		.rd_addr(FB_AW'(idx_q)), .rd_data(fbt_rd)
	);

	ciir_ram #(.DEPTH(MAX_FORWARD_TAPS), .WIDTH(2*SB), .AW(FF_AW)) u_in_hist (
		.clk(clk), .arst_n(arst_n),
		.wr_en(finish_go && !zero_q), .wr_addr(ipos_q), .wr_data(x_q),
		.rd_addr(ih_addr), .rd_data(ih_rd)
	);

	ciir_ram #(.DEPTH(MAX_FEEDBACK_TAPS), .WIDTH(2*SB), .AW(FB_AW)) u_out_hist (
		.clk(clk), .arst_n(arst_n),
		.wr_en(finish_go && !zero_q), .wr_addr(opos_q), .wr_data(y_cplx),
		.rd_addr(oh_addr), .rd_data(oh_rd)
	);

	// tap 0 of the feedforward path takes the current sample
	assign mac_tap = fb_s1 ? ciir_pkg::coef_cplx_t'(fbt_rd) : ciir_pkg::coef_cplx_t'(fft_rd);
	assign mac_smp = fb_s1 ? ciir_pkg::sample_cplx_t'(oh_rd) :
		(selx_s1 ? x_q : ciir_pkg::sample_cplx_t'(ih_rd));

	ciir_cmac #(.ACC_BITS(ACC_BITS)) u_cmac (
		.clk(clk), .arst_n(arst_n),
		.clr(mac_clr), .en(rd_s1),
		.tap(mac_tap), .smp(mac_smp),
		.busy(mac_busy), .acc_re(acc_re), .acc_im(acc_im)
	);

	assign rs_re = round_sat(acc_re);
	assign rs_im = round_sat(acc_im);
	assign y_cplx = {rs_re[SB-1:0], rs_im[SB-1:0]};

	always_comb begin
		if (zero_q) begin
			y_word = '0;
		end else begin
			y_word.out_re = rs_re[SB-1:0];
			y_word.out_im = rs_im[SB-1:0];
			y_word.clipped = rs_re[SB] | rs_im[SB];
		end
	end

	assign result_valid = res_valid_q;
	assign result_word = res_q;

endmodule

### hdl/ciir_checker.sv
// ----------------------------------------------------------------------------
// ciir_checker
// Port-level checks on the complex IIR filter, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "complex_iir_filter_top_defines.svh"

module ciir_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                sample_valid,
	input logic                                sample_stall,
	input ciir_pkg::sample_word_t              sample_word,
	input logic                                result_valid,
	input logic                                result_stall,
	input ciir_pkg::result_word_t              result_word
);

	// a stalled result word stays and holds
	`CIIR_ASSERT_NXT(a_res_hold, clk, arst_n, result_valid && result_stall, result_valid && $stable(result_word))

	// a filter word keeps the input stalled while it is worked
	`CIIR_ASSERT_NXT(a_busy_after_filter, clk, arst_n, sample_valid && !sample_stall && sample_word.action == ciir_pkg::ACT_FILTER, sample_stall)

	// clip flag means at least one part sits at a rail
	`CIIR_ASSERT_IMP(a_clip_rail, clk, arst_n, result_valid && result_word.clipped, result_word.out_re == ciir_pkg::SAMPLE_MAX || result_word.out_re == ciir_pkg::SAMPLE_MIN || result_word.out_im == ciir_pkg::SAMPLE_MAX || result_word.out_im == ciir_pkg::SAMPLE_MIN)

	// no result can come out the cycle right after a filter word is taken while no result waits
	`CIIR_ASSERT_NXT(a_no_instant_result, clk, arst_n, sample_valid && !sample_stall && sample_word.action == ciir_pkg::ACT_FILTER && !result_valid, !result_valid)

endmodule

bind complex_iir_filter_top ciir_checker u_ciir_checker (.*);
